// ===== design/rcl_pkg.sv =====
// rcl_pkg: shared widths, constants and the command/status types of the
// rms current limiter. No dependencies; used by every design file.

package rcl_pkg;

  // window length; a power of two turns the mean into a shift
  localparam int WINDOW_LEN = 1024;
  localparam int WIN_AW     = $clog2(WINDOW_LEN);
  localparam int WFILL_W    = $clog2(WINDOW_LEN + 1);
  localparam bit WIN_POW2   = (WINDOW_LEN & (WINDOW_LEN - 1)) == 0;

  localparam int SAMPLE_W = 16;
  localparam int GSUM_W   = 25;
  localparam int FILL_W   = 9;
  localparam int CC_W     = 15;
  localparam int CNT_W    = 9;
  localparam int CFG_W    = 15;
  localparam int RMS_W    = 16;
  localparam int LIM_W    = 20;

  // group magnitude is at most 511 * 32768 < 2**24
  localparam int MAG_W    = 24;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = SQ_W + WIN_AW;
  localparam int ROOT_W   = (SUM_W + 1) / 2;
  localparam int OPR_W    = 2 * ROOT_W;
  localparam int CCSQ_W   = 2 * CC_W;
  localparam int BPROD_W  = CCSQ_W + WFILL_W;
  localparam int DIVR_W   = (CNT_W > WFILL_W) ? CNT_W : WFILL_W;
  localparam int STEP_W   = $clog2(SUM_W + 1);

  localparam logic [WFILL_W-1:0] WIN_LEN_C  = WFILL_W'(WINDOW_LEN);
  localparam logic [WIN_AW-1:0]  WIN_LAST_C = WIN_AW'(WINDOW_LEN - 1);
  localparam logic [LIM_W-1:0]   LIM_MAX    = {LIM_W{1'b1}};

  localparam logic [STEP_W-1:0] AVG_STEPS_M1  = STEP_W'(MAG_W - 1);
  localparam logic [STEP_W-1:0] WIN_STEPS_M1  = STEP_W'(SUM_W - 1);
  localparam logic [STEP_W-1:0] ROOT_STEPS_M1 = STEP_W'(ROOT_W - 1);

  // configuration register indexes
  localparam logic CFG_CONT_CURRENT = 1'b0;
  localparam logic CFG_SUBSAMPLE    = 1'b1;

  // input kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef struct packed {
    logic accum;
    logic clear;
    logic avg_load;
    logic div_step;
    logic square;
    logic update;
    logic budget_sq;
    logic budget_mul;
    logic win_load;
    logic root_load;
    logic root_step;
    logic finish;
    logic post;
    logic post_updated;
  } dp_cmd_t;

  typedef struct packed {
    logic group_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/rms_current_limiter.sv =====
// rms_current_limiter: top level, joins the sequencer and the datapath.
// Needs rcl_pkg, rcl_ctrl and rcl_datapath.
//
// Input stream: s_tdata carries one signed current sample, s_tuser the kind
// (sample or clear). Every input transfer yields exactly one result transfer
// on the m_ stream carrying the held rms current, the allowed peak current
// and a flag that is set when this item closed a group or was a clear.
// Items are handled one at a time. A sample that does not close a group goes
// from the group check straight to result posting. A sample that closes a
// group, or a clear, runs the group-average divider (24 steps) and the window
// update, both skipped on clear, then the budget multiply and the two
// square-root units (29 steps, in parallel); a window length that is not a
// power of two adds a 58-step mean divider.
// The output register frees the input side: the next item is taken while a
// result still waits, and only its own result posting waits for m_tready.
// Synchronous reset empties the group, window and running sum and zeroes
// both held outputs; the window memory needs no clearing pass.
// Configuration writes are taken at any edge with cfg_we high.

module rms_current_limiter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] sample
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [15:0] rms_current, [35:16] max_current, [39:36] zero
  output logic        m_tuser    // [0] updated
);

  rcl_pkg::dp_cmd_t    cmd;
  rcl_pkg::dp_status_t status;

  rcl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .kind     (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rcl_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// ===== design/rcl_div.sv =====
// rcl_div: restoring divider, one quotient bit per step.
// Uses rcl_pkg widths; shared for the group average and the window mean.

module rcl_div (
  input  logic                      clk,
  input  logic                      load,
  input  logic                      step,
  input  logic [rcl_pkg::SUM_W-1:0]  dividend,
  input  logic [rcl_pkg::DIVR_W-1:0] divisor,
  output logic [rcl_pkg::SUM_W-1:0]  quotient
);

  logic [rcl_pkg::DIVR_W-1:0] rem;
  logic [rcl_pkg::DIVR_W-1:0] dvs;
  logic [rcl_pkg::SUM_W-1:0]  quo;
  logic [rcl_pkg::DIVR_W:0]   shifted;
  logic [rcl_pkg::DIVR_W:0]   diff;
  logic                       ge;

  assign shifted  = {rem, quo[rcl_pkg::SUM_W-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign ge       = shifted >= {1'b0, dvs};
  assign quotient = quo;

  // dividend bits shift out the top while quotient bits fill in below
  always_ff @(posedge clk) begin
    if (load) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (step) begin
      rem <= ge ? diff[rcl_pkg::DIVR_W-1:0] : shifted[rcl_pkg::DIVR_W-1:0];
      quo <= {quo[rcl_pkg::SUM_W-2:0], ge};
    end
  end

endmodule

// ===== design/rcl_sqrt.sv =====
// rcl_sqrt: digit-by-digit floor square root, one result bit per step.
// Uses rcl_pkg widths; instantiated for the rms value and the peak limit.

module rcl_sqrt (
  input  logic                      clk,
  input  logic                      load,
  input  logic                      step,
  input  logic [rcl_pkg::OPR_W-1:0]  operand,
  output logic [rcl_pkg::ROOT_W-1:0] root
);

  logic [rcl_pkg::OPR_W-1:0]  opr;
  logic [rcl_pkg::ROOT_W:0]   rem;
  logic [rcl_pkg::ROOT_W-1:0] res;
  logic [rcl_pkg::ROOT_W+2:0] shifted;
  logic [rcl_pkg::ROOT_W+2:0] trial;
  logic [rcl_pkg::ROOT_W+2:0] diff;
  logic                       ge;

  assign shifted = {rem, opr[rcl_pkg::OPR_W-1 -: 2]};
  assign trial   = {1'b0, res, 2'b01};
  assign diff    = shifted - trial;
  assign ge      = shifted >= trial;
  assign root    = res;

  always_ff @(posedge clk) begin
    if (load) begin
      opr <= operand;
      rem <= '0;
      res <= '0;
    end else if (step) begin
      opr <= {opr[rcl_pkg::OPR_W-3:0], 2'b00};
      rem <= ge ? diff[rcl_pkg::ROOT_W:0] : shifted[rcl_pkg::ROOT_W:0];
      res <= {res[rcl_pkg::ROOT_W-2:0], ge};
    end
  end

endmodule

// ===== design/rcl_datapath.sv =====
// rcl_datapath: config registers, group accumulator, square window memory,
// running sum, divider and root units, output register. Needs rcl_pkg,
// rcl_div and rcl_sqrt.

module rcl_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [rcl_pkg::CFG_W-1:0]    cfg_data,
  input  logic [rcl_pkg::SAMPLE_W-1:0] sample,
  input  rcl_pkg::dp_cmd_t            cmd,
  output rcl_pkg::dp_status_t         status,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [39:0]                 m_tdata,
  output logic                        m_tuser
);

  logic [rcl_pkg::CC_W-1:0]    rated_current;
  logic [rcl_pkg::CNT_W-1:0]   subsample_count;
  logic [rcl_pkg::CNT_W-1:0]   count_eff;

  logic signed [rcl_pkg::GSUM_W-1:0] group_sum;
  logic [rcl_pkg::FILL_W-1:0]  group_fill;
  logic [rcl_pkg::WIN_AW-1:0]  window_pointer;
  logic [rcl_pkg::WFILL_W-1:0] window_fill;
  logic [rcl_pkg::SUM_W-1:0]   square_sum;
  logic [rcl_pkg::RMS_W-1:0]   rms_value;
  logic [rcl_pkg::LIM_W-1:0]   limit_value;

  logic [rcl_pkg::SQ_W-1:0]    square_window [rcl_pkg::WINDOW_LEN];
  logic [rcl_pkg::SQ_W-1:0]    old_sq;
  logic [rcl_pkg::SQ_W-1:0]    sq;
  logic [rcl_pkg::CCSQ_W-1:0]  ccsq;
  logic [rcl_pkg::BPROD_W-1:0] budget_prod;
  logic [rcl_pkg::SUM_W-1:0]   budget;

  logic                        window_full;
  logic [rcl_pkg::GSUM_W-1:0]  mag_full;
  logic [rcl_pkg::MAG_W-1:0]   avg;
  logic [rcl_pkg::SUM_W-1:0]   div_dividend;
  logic [rcl_pkg::DIVR_W-1:0]  div_divisor;
  logic [rcl_pkg::SUM_W-1:0]   quotient;
  logic [rcl_pkg::SUM_W-1:0]   mean_sq;
  logic [rcl_pkg::SUM_W-1:0]   headroom;
  logic [rcl_pkg::ROOT_W-1:0]  rms_root;
  logic [rcl_pkg::ROOT_W-1:0]  lim_root;

  assign count_eff   = (subsample_count == '0) ? rcl_pkg::CNT_W'(1) : subsample_count;
  assign window_full = window_fill == rcl_pkg::WIN_LEN_C;
  assign mag_full    = group_sum[rcl_pkg::GSUM_W-1] ? -group_sum : group_sum;
  assign avg         = quotient[rcl_pkg::MAG_W-1:0];
  assign budget_prod = ccsq * rcl_pkg::WIN_LEN_C;

  // magnitude goes in left-aligned so its quotient lands in the low bits
  always_comb begin
    if (cmd.avg_load) begin
      div_dividend = {mag_full[rcl_pkg::MAG_W-1:0], {rcl_pkg::SUM_W-rcl_pkg::MAG_W{1'b0}}};
      div_divisor  = rcl_pkg::DIVR_W'(count_eff);
    end else begin
      div_dividend = square_sum;
      div_divisor  = rcl_pkg::DIVR_W'(rcl_pkg::WINDOW_LEN);
    end
  end

  assign mean_sq  = rcl_pkg::WIN_POW2 ? (square_sum >> rcl_pkg::WIN_AW) : quotient;
  assign headroom = (square_sum < budget) ? (budget - square_sum) : '0;

  rcl_div u_div (
    .clk      (clk),
    .load     (cmd.avg_load | cmd.win_load),
    .step     (cmd.div_step),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient)
  );

  rcl_sqrt u_rms_root (
    .clk     (clk),
    .load    (cmd.root_load),
    .step    (cmd.root_step),
    .operand (rcl_pkg::OPR_W'(mean_sq)),
    .root    (rms_root)
  );

  rcl_sqrt u_lim_root (
    .clk     (clk),
    .load    (cmd.root_load),
    .step    (cmd.root_step),
    .operand (rcl_pkg::OPR_W'(headroom)),
    .root    (lim_root)
  );

  assign status.group_done = group_fill >= count_eff;
  assign status.out_free   = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rated_current   <= '0;
      subsample_count <= rcl_pkg::CNT_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == rcl_pkg::CFG_CONT_CURRENT) begin
        rated_current <= cfg_data[rcl_pkg::CC_W-1:0];
      end else begin
        subsample_count <= cfg_data[rcl_pkg::CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_sum      <= '0;
      group_fill     <= '0;
      window_pointer <= '0;
      window_fill    <= '0;
      square_sum     <= '0;
      rms_value      <= '0;
      limit_value    <= '0;
    end else begin
      if (cmd.clear) begin
        group_sum      <= '0;
        group_fill     <= '0;
        window_pointer <= '0;
        window_fill    <= '0;
        square_sum     <= '0;
      end
      if (cmd.accum) begin
        group_sum  <= group_sum + rcl_pkg::GSUM_W'(signed'(sample));
        group_fill <= group_fill + rcl_pkg::FILL_W'(1);
      end
      // oldest square leaves before the new one enters
      if (cmd.square && window_full) begin
        square_sum <= square_sum - rcl_pkg::SUM_W'(old_sq);
      end
      if (cmd.update) begin
        square_sum     <= square_sum + rcl_pkg::SUM_W'(sq);
        window_pointer <= (window_pointer == rcl_pkg::WIN_LAST_C) ? '0
                          : window_pointer + rcl_pkg::WIN_AW'(1);
        if (!window_full) begin
          window_fill <= window_fill + rcl_pkg::WFILL_W'(1);
        end
        group_sum  <= '0;
        group_fill <= '0;
      end
      if (cmd.finish) begin
        rms_value   <= rms_root[rcl_pkg::RMS_W-1:0];
        limit_value <= (lim_root > rcl_pkg::ROOT_W'(rcl_pkg::LIM_MAX)) ? rcl_pkg::LIM_MAX
                       : lim_root[rcl_pkg::LIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.avg_load) begin
      old_sq <= square_window[window_pointer];
    end
    if (cmd.update) begin
      square_window[window_pointer] <= sq;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sq <= avg * avg;
    end
    if (cmd.budget_sq) begin
      ccsq <= rated_current * rated_current;
    end
    if (cmd.budget_mul) begin
      budget <= rcl_pkg::SUM_W'(budget_prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.post) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      m_tdata <= {4'b0000, limit_value, rms_value};
      m_tuser <= cmd.post_updated;
    end
  end

  a_pointer_range : assert property (@(posedge clk) disable iff (rst)
    window_pointer <= rcl_pkg::WIN_LAST_C)
    else $error("window pointer out of range");

  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    window_fill <= rcl_pkg::WIN_LEN_C)
    else $error("window fill beyond window length");

  a_clear_empties : assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (square_sum == '0) && (window_fill == '0) && (group_fill == '0))
    else $error("clear left state behind");

  a_post_has_room : assert property (@(posedge clk) disable iff (rst)
    cmd.post |-> status.out_free)
    else $error("result posted over a pending transfer");

  a_update_after_group : assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> (group_fill == '0) && (window_fill != '0))
    else $error("window update did not close the group");

endmodule

// ===== design/rcl_ctrl.sv =====
// rcl_ctrl: sequencer for one item at a time through the datapath.
// Needs rcl_pkg for the command and status types and the step counts.

module rcl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                kind,
  output logic                s_tready,
  input  rcl_pkg::dp_status_t status,
  output rcl_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    IDLE, CHECK, DIV_AVG, SQUARE, UPDATE, BUDGET_SQ, BUDGET_MUL,
    DIV_WIN, ROOT_LOAD, ROOT, FINISH, POST
  } state_t;

  state_t                     state;
  logic [rcl_pkg::STEP_W-1:0] steps;
  logic                       updated;

  assign s_tready = state == IDLE;

  always_comb begin
    cmd = '0;
    cmd.post_updated = updated;
    case (state)
      IDLE: begin
        cmd.accum = s_tvalid && (kind == rcl_pkg::KIND_SAMPLE);
        cmd.clear = s_tvalid && (kind == rcl_pkg::KIND_CLEAR);
      end
      CHECK:      cmd.avg_load   = status.group_done;
      DIV_AVG:    cmd.div_step   = 1'b1;
      SQUARE:     cmd.square     = 1'b1;
      UPDATE:     cmd.update     = 1'b1;
      BUDGET_SQ:  cmd.budget_sq  = 1'b1;
      BUDGET_MUL: begin
        cmd.budget_mul = 1'b1;
        cmd.win_load   = !rcl_pkg::WIN_POW2;
      end
      DIV_WIN:    cmd.div_step   = 1'b1;
      ROOT_LOAD:  cmd.root_load  = 1'b1;
      ROOT:       cmd.root_step  = 1'b1;
      FINISH:     cmd.finish     = 1'b1;
      POST:       cmd.post       = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      steps   <= '0;
      updated <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            if (kind == rcl_pkg::KIND_CLEAR) begin
              updated <= 1'b1;
              state   <= BUDGET_SQ;
            end else begin
              state <= CHECK;
            end
          end
        end
        CHECK: begin
          if (status.group_done) begin
            updated <= 1'b1;
            steps   <= rcl_pkg::AVG_STEPS_M1;
            state   <= DIV_AVG;
          end else begin
            updated <= 1'b0;
            state   <= POST;
          end
        end
        DIV_AVG: begin
          steps <= steps - rcl_pkg::STEP_W'(1);
          if (steps == '0) begin
            state <= SQUARE;
          end
        end
        SQUARE:    state <= UPDATE;
        UPDATE:    state <= BUDGET_SQ;
        BUDGET_SQ: state <= BUDGET_MUL;
        BUDGET_MUL: begin
          if (rcl_pkg::WIN_POW2) begin
            state <= ROOT_LOAD;
          end else begin
            steps <= rcl_pkg::WIN_STEPS_M1;
            state <= DIV_WIN;
          end
        end
        DIV_WIN: begin
          steps <= steps - rcl_pkg::STEP_W'(1);
          if (steps == '0) begin
            state <= ROOT_LOAD;
          end
        end
        ROOT_LOAD: begin
          steps <= rcl_pkg::ROOT_STEPS_M1;
          state <= ROOT;
        end
        ROOT: begin
          steps <= steps - rcl_pkg::STEP_W'(1);
          if (steps == '0) begin
            state <= FINISH;
          end
        end
        FINISH: state <= POST;
        POST: begin
          if (status.out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_accept_only_idle : assert property (@(posedge clk) disable iff (rst)
    (cmd.accum || cmd.clear) |-> (state == IDLE) && s_tvalid)
    else $error("item taken outside idle");

  a_check_follows_sample : assert property (@(posedge clk) disable iff (rst)
    cmd.accum |=> state == CHECK)
    else $error("sample not followed by group check");

  a_root_ends : assert property (@(posedge clk) disable iff (rst)
    (state == ROOT) && (steps == '0) |=> state == FINISH)
    else $error("root iteration did not finish");

endmodule

// ===== test/rms_current_limiter_tb.sv =====
`timescale 1ns / 100ps
// rms_current_limiter_tb: self-checking bench for the rms current limiter stream block.
// Depends on rcl_pkg and rms_current_limiter; holds its own window/rms predictor.

module rms_current_limiter_tb;

  localparam int   WINDOW_LEN       = rcl_pkg::WINDOW_LEN;
  localparam logic CFG_CONT_CURRENT = rcl_pkg::CFG_CONT_CURRENT;
  localparam logic CFG_SUBSAMPLE    = rcl_pkg::CFG_SUBSAMPLE;
  localparam logic KIND_SAMPLE      = rcl_pkg::KIND_SAMPLE;
  localparam logic KIND_CLEAR       = rcl_pkg::KIND_CLEAR;

  typedef struct packed {
    logic [15:0] rms;
    logic [19:0] lim;
    logic        upd;
  } result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_op_t;

  typedef struct packed {
    row_op_t            op;
    logic               reg_idx;
    logic [14:0]        reg_val;
    logic               kind;
    logic signed [15:0] sample;
    logic               typed;
    result_t            want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [14:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [15:0] sample
  logic        s_tuser = 1'b0; // [0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [15:0] rms_current, [35:16] max_current, [39:36] zero
  logic        m_tuser;        // [0] updated

  rms_current_limiter dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [14:0]       cur_cc = '0;
  logic [8:0]        cur_cnt = 9'd1;
  longint            grp_sum = 0;
  logic [8:0]        grp_fill = '0;
  longint unsigned   sq_hist [WINDOW_LEN];
  int                hist_ptr = 0;
  int                hist_fill = 0;
  longint unsigned   sq_total = 0;
  logic [15:0]       held_rms = '0;
  logic [19:0]       held_lim = '0;

  result_t pending_limits [$];
  int      mismatch_count = 0;
  int      rx_count = 0;
  bit      calm = 1'b0;

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic void refresh_limits();
    longint unsigned budget, root;
    budget = longint'(cur_cc) * longint'(cur_cc) * WINDOW_LEN;
    held_rms = 16'(floor_root(sq_total / WINDOW_LEN));
    if (sq_total >= budget) begin
      held_lim = '0;
    end else begin
      root = floor_root(budget - sq_total);
      held_lim = (root > 64'd1048575) ? 20'hFFFFF : 20'(root);
    end
  endfunction

  function automatic result_t predict_limits(logic kind, logic signed [15:0] smp);
    result_t         r;
    longint unsigned per_group, mag, sq;
    r.upd = 1'b0;
    if (kind == KIND_CLEAR) begin
      grp_sum = 0;
      grp_fill = '0;
      hist_ptr = 0;
      hist_fill = 0;
      sq_total = 0;
      refresh_limits();
      r.upd = 1'b1;
    end else begin
      per_group = (cur_cnt == 0) ? 1 : longint'(cur_cnt);
      grp_sum += smp;
      grp_fill = grp_fill + 9'd1;
      if (longint'(grp_fill) >= per_group) begin
        mag = (grp_sum < 0) ? longint'(-grp_sum) : longint'(grp_sum);
        sq = (mag / per_group) * (mag / per_group);
        if (hist_fill >= WINDOW_LEN) sq_total -= sq_hist[hist_ptr];
        else hist_fill++;
        sq_total += sq;
        sq_hist[hist_ptr] = sq;
        hist_ptr = (hist_ptr + 1) % WINDOW_LEN;
        refresh_limits();
        grp_sum = 0;
        grp_fill = '0;
        r.upd = 1'b1;
      end
    end
    r.rms = held_rms;
    r.lim = held_lim;
    return r;
  endfunction

  task automatic send_item(input logic kind, input logic signed [15:0] smp,
                           input logic typed, input result_t typed_res);
    result_t r;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= smp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = predict_limits(kind, smp);
    pending_limits.push_back(typed ? typed_res : r);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(input logic idx, input logic [14:0] val);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_limits.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CONT_CURRENT) cur_cc = val;
    else cur_cnt = val[8:0];
  endtask

  task automatic run_phase(input logic [14:0] cc, input logic [8:0] cnt,
                           input int n_items, input int clear_pct);
    logic               kind;
    logic signed [15:0] smp;
    int                 pick;
    write_reg(CFG_CONT_CURRENT, cc);
    write_reg(CFG_SUBSAMPLE, 15'(cnt));
    repeat (n_items) begin
      kind = ($urandom_range(0, 99) < clear_pct) ? KIND_CLEAR : KIND_SAMPLE;
      pick = $urandom_range(0, 19);
      if (pick < 2) smp = 16'sh8000;
      else if (pick < 4) smp = 16'sh7FFF;
      else if (pick == 4) smp = 16'sd0;
      else if (pick == 5) smp = -16'sd1;
      else if (pick < 8) smp = 16'($signed($urandom_range(0, 63)) - 32);
      else smp = 16'($urandom);
      send_item(kind, smp, 1'b0, '0);
    end
  endtask

  dir_row_t directed_rows [27] = '{
    '{ROW_ITEM, CFG_CONT_CURRENT, 15'd0, KIND_CLEAR, 16'sd0, 1'b1, '{16'd0, 20'd0, 1'b1}},
    '{ROW_ITEM, CFG_CONT_CURRENT, 15'd0, KIND_SAMPLE, 16'sd0, 1'b1, '{16'd0, 20'd0, 1'b1}},
    '{ROW_ITEM, CFG_CONT_CURRENT, 15'd0, KIND_SAMPLE, 16'sh7FFF, 1'b0, '0},
    '{ROW_ITEM, CFG_CONT_CURRENT, 15'd0, KIND_SAMPLE, 16'sh8000, 1'b0, '0},
    '{ROW_CFG, CFG_CONT_CURRENT, 15'h7FFF, KIND_SAMPLE, 16'sd0, 1'b0, '0},
    '{ROW_ITEM, CFG_CONT_CURRENT, 15'd0, KIND_CLEAR, 16'sh1234, 1'b1,
      '{16'd0, 20'd1048544, 1'b1}},
    '{ROW_ITEM, CFG_CONT_CURRENT, 15'd0, KIND_SAMPLE, -16'sd1, 1'b0, '0},
    '{ROW_ITEM, CFG_CONT_CURRENT, 15'd0, KIND_SAMPLE, 16'sh5555, 1'b0, '0},
    '{ROW_ITEM, CFG_CONT_CURRENT, 15'd0, KIND_SAMPLE, 16'shAAAA, 1'b0, '0},
    '{ROW_CFG, CFG_SUBSAMPLE, 15'd0, KIND_SAMPLE, 16'sd0, 1'b0, '0},
    '{ROW_ITEM, CFG_CONT_CURRENT, 15'd0, KIND_SAMPLE, 16'sd100, 1'b0, '0},
    '{ROW_CFG, CFG_SUBSAMPLE, 15'd4, KIND_SAMPLE, 16'sd0, 1'b0, '0},
    '{ROW_ITEM, CFG_CONT_CURRENT, 15'd0, KIND_SAMPLE, 16'sd1000, 1'b0, '0},
    '{ROW_ITEM, CFG_CONT_CURRENT, 15'd0, KIND_SAMPLE, -16'sd3000, 1'b0, '0},
    // count lowered to the fill already gathered
    '{ROW_CFG, CFG_SUBSAMPLE, 15'd2, KIND_SAMPLE, 16'sd0, 1'b0, '0},
    '{ROW_ITEM, CFG_CONT_CURRENT, 15'd0, KIND_SAMPLE, 16'sd7, 1'b0, '0},
    '{ROW_CFG, CFG_SUBSAMPLE, 15'd3, KIND_SAMPLE, 16'sd0, 1'b0, '0},
    '{ROW_ITEM, CFG_CONT_CURRENT, 15'd0, KIND_SAMPLE, -16'sd5, 1'b0, '0},
    '{ROW_ITEM, CFG_CONT_CURRENT, 15'd0, KIND_SAMPLE, -16'sd5, 1'b0, '0},
    '{ROW_ITEM, CFG_CONT_CURRENT, 15'd0, KIND_SAMPLE, -16'sd6, 1'b0, '0},
    '{ROW_CFG, CFG_SUBSAMPLE, 15'd511, KIND_SAMPLE, 16'sd0, 1'b0, '0},
    '{ROW_ITEM, CFG_CONT_CURRENT, 15'd0, KIND_SAMPLE, 16'sh8000, 1'b0, '0},
    // clear in the middle of a group
    '{ROW_ITEM, CFG_CONT_CURRENT, 15'd0, KIND_CLEAR, 16'sh7FFF, 1'b1,
      '{16'd0, 20'd1048544, 1'b1}},
    '{ROW_CFG, CFG_CONT_CURRENT, 15'd0, KIND_SAMPLE, 16'sd0, 1'b0, '0},
    '{ROW_CFG, CFG_SUBSAMPLE, 15'd1, KIND_SAMPLE, 16'sd0, 1'b0, '0},
    '{ROW_ITEM, CFG_CONT_CURRENT, 15'd0, KIND_SAMPLE, 16'sd1, 1'b1, '{16'd0, 20'd0, 1'b1}},
    '{ROW_ITEM, CFG_CONT_CURRENT, 15'd0, KIND_SAMPLE, 16'sh7FFF, 1'b0, '0}
  };

  // result side: check, random stalls and one long hold-off
  initial begin
    result_t want;
    int      stall_left;
    int      hold_left;
    bit      pressure_done;
    stall_left = 0;
    hold_left = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        rx_count++;
        if (pending_limits.size() == 0) begin
          $display("%0t: result with none expected, rms %0d max %0d updated %0d",
                   $time, m_tdata[15:0], m_tdata[35:16], m_tuser);
          mismatch_count++;
        end else begin
          want = pending_limits.pop_front();
          if (m_tdata[15:0] !== want.rms) begin
            $display("%0t: rms_current expected %0d got %0d", $time, want.rms, m_tdata[15:0]);
            mismatch_count++;
          end
          if (m_tdata[35:16] !== want.lim) begin
            $display("%0t: max_current expected %0d got %0d", $time, want.lim,
                     m_tdata[35:16]);
            mismatch_count++;
          end
          if (m_tuser !== want.upd) begin
            $display("%0t: updated expected %0d got %0d", $time, want.upd, m_tuser);
            mismatch_count++;
          end
        end
      end
      if (!pressure_done && rx_count == 400) begin
        hold_left = 300;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 13);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_CFG)
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      else
        send_item(directed_rows[i].kind, directed_rows[i].sample,
                  directed_rows[i].typed, directed_rows[i].want);
    end
    // enough single-sample groups to wrap the window
    run_phase(15'h7FFF, 9'd1, 1030, 0);
    run_phase(15'($urandom_range(0, 32767)), 9'($urandom_range(1, 8)), 100, 5);
    run_phase(15'($urandom_range(0, 2000)), 9'($urandom_range(2, 5)), 50, 5);
    calm = 1'b1;
    run_phase(15'($urandom_range(0, 32767)), 9'd1, 40, 3);
    s_tvalid <= 1'b0;
    while (pending_limits.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #16_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
design/rcl_pkg.sv
design/rcl_div.sv
design/rcl_sqrt.sv
design/rcl_datapath.sv
design/rcl_ctrl.sv
design/rms_current_limiter.sv
test/rms_current_limiter_tb.sv
